// ===== src/numlex_pkg.sv =====
// Shared types, constants and helper functions of the numeric literal scanner.
// No dependencies; imported by every module of the block.
package numlex_pkg;

   // Length saturates here; the reported length field also saturates at 255.
   localparam int LENGTH_LIMIT = 255;
   localparam int LEN_W        = $clog2(LENGTH_LIMIT + 1);
   localparam int VALUE_W      = 63;
   localparam int MAC_W        = VALUE_W + 4;   // room for accum * 16 + 15

   localparam int REQ_TDATA_W  = 8;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_FIELDS_W = 2 + VALUE_W + 8;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Character codes
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ZERO     = 4'd1,
      PH_INT      = 4'd2,
      PH_DOT      = 4'd3,
      PH_FRAC     = 4'd4,
      PH_EXP_E    = 4'd5,
      PH_EXP_SIGN = 4'd6,
      PH_EXP_DIG  = 4'd7,
      PH_PREFIX   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      KIND_INT      = 2'd0,
      KIND_OVERFLOW = 2'd1,
      KIND_FLOAT    = 2'd2,
      KIND_NO_DIGIT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       begin_req;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      phase_type            phase;
      logic [VALUE_W-1:0]   accum;
      logic                 too_big;
      logic [LEN_W-1:0]     len;
      logic                 is_frac;
      radix_type            radix;
   } scan_state_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic [7:0]         length;
   } result_type;

   localparam scan_state_type SCAN_RESET = '{
      phase:   PH_IDLE,
      accum:   '0,
      too_big: 1'b0,
      len:     '0,
      is_frac: 1'b0,
      radix:   RADIX_DEC
   };

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   // Saturating add of 1..3 characters to the committed length
   function automatic logic [LEN_W-1:0] commit_len(input logic [LEN_W-1:0] l,
                                                   input logic [1:0] k);
      logic [LEN_W:0] n;
      n = {1'b0, l} + (LEN_W+1)'(k);
      if (n > (LEN_W+1)'(LENGTH_LIMIT)) begin
         return LEN_W'(LENGTH_LIMIT);
      end
      return n[LEN_W-1:0];
   endfunction

   function automatic logic [7:0] sat_len8(input logic [LEN_W-1:0] l);
      if (int'(l) > 255) begin
         return 8'hFF;
      end
      return 8'(l);
   endfunction

   // Closing a literal at end of text: a pending dot is taken as a fraction
   function automatic scan_state_type end_state(input scan_state_type s);
      scan_state_type r;
      r = s;
      if (s.phase == PH_DOT) begin
         r.len     = commit_len(s.len, 2'd1);
         r.is_frac = 1'b1;
      end
      return r;
   endfunction

   function automatic result_type finish(input scan_state_type s);
      result_type r;
      r.value  = '0;
      r.length = sat_len8(s.len);
      if (s.phase == PH_PREFIX && s.len <= LEN_W'(2)) begin
         r.kind = KIND_NO_DIGIT;
      end else if (s.is_frac) begin
         r.kind = KIND_FLOAT;
      end else if (s.too_big) begin
         r.kind = KIND_OVERFLOW;
      end else begin
         r.kind  = KIND_INT;
         r.value = s.accum;
      end
      return r;
   endfunction

   function automatic scan_state_type start_state(input logic [7:0] c);
      scan_state_type r;
      r = SCAN_RESET;
      if (is_dec(c)) begin
         r.len   = LEN_W'(1);
         r.accum = VALUE_W'(c - CH_0);
         r.phase = (c == CH_0) ? PH_ZERO : PH_INT;
      end
      return r;
   endfunction

endpackage

// ===== src/numlex_in_stage.sv =====
// Input register of the scanner: holds one character transfer until the
// step logic takes it. Depends on numlex_pkg.
module numlex_in_stage
   import numlex_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   advance,
   output logic                   item_valid,
   output item_type               item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
      if (take) begin
         item_in.ch          = req_tdata;
         item_in.begin_req   = req_tuser[0];
         item_in.end_of_text = req_tuser[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/numlex_step.sv =====
// Per-character next-state and result logic of the scanner, including the
// radix multiply-add with overflow detect. Depends on numlex_pkg.
module numlex_step
   import numlex_pkg::*;
(
   input  scan_state_type cur,
   input  item_type       item,
   output scan_state_type nxt,
   output logic           emit,
   output result_type     result
);

   logic [7:0]       c;
   logic [3:0]       digit;
   logic             dig_ok;
   logic [MAC_W-1:0] acc_ext, scaled, mac;
   logic             mac_over;
   scan_state_type   w, fin_w;
   logic             done, fin, try_exp;

   assign c = item.ch;

   // Digit value in the current radix
   always_comb begin
      digit  = 4'(c - CH_0);
      dig_ok = 1'b0;
      unique case (cur.radix)
         RADIX_BIN: dig_ok = (c == CH_0) || (c == CH_1);
         RADIX_HEX: begin
            if (is_dec(c)) begin
               dig_ok = 1'b1;
            end else if (c >= CH_LA && c <= CH_LF) begin
               dig_ok = 1'b1;
               digit  = 4'(c - CH_LA + 8'd10);
            end else if (c >= CH_UA && c <= CH_UF) begin
               dig_ok = 1'b1;
               digit  = 4'(c - CH_UA + 8'd10);
            end
         end
         default: dig_ok = is_dec(c);
      endcase
   end

   // accum * radix + digit; anything above 2^63-1 is overflow
   assign acc_ext = MAC_W'(cur.accum);
   always_comb begin
      unique case (cur.radix)
         RADIX_HEX: scaled = acc_ext << 4;
         RADIX_BIN: scaled = acc_ext << 1;
         default:   scaled = (acc_ext << 3) + (acc_ext << 1);
      endcase
   end
   assign mac      = scaled + MAC_W'(digit);
   assign mac_over = |mac[MAC_W-1:VALUE_W];

   always_comb begin
      w       = cur;
      nxt     = cur;
      fin_w   = cur;
      emit    = 1'b0;
      done    = 1'b0;
      fin     = 1'b0;
      try_exp = 1'b0;
      if (item.end_of_text) begin
         if (cur.phase != PH_IDLE) begin
            emit      = 1'b1;
            fin_w     = end_state(cur);
            nxt.phase = PH_IDLE;
         end
      end else if (item.begin_req) begin
         if (cur.phase != PH_IDLE) begin
            emit  = 1'b1;
            fin_w = end_state(cur);
         end
         nxt = start_state(c);
      end else if (cur.phase != PH_IDLE) begin
         if (w.phase == PH_ZERO) begin
            if (c == CH_LX || c == CH_UX || c == CH_LB || c == CH_UB) begin
               w.radix = (c == CH_LX || c == CH_UX) ? RADIX_HEX : RADIX_BIN;
               w.len   = commit_len(w.len, 2'd1);
               w.accum = '0;
               w.phase = PH_PREFIX;
               done    = 1'b1;
            end else begin
               w.phase = PH_INT;
            end
         end
         // a dot is only kept once the next character is not a second dot
         if (!done && w.phase == PH_DOT) begin
            if (c == CH_DOT) begin
               fin  = 1'b1;
               done = 1'b1;
            end else begin
               w.len     = commit_len(w.len, 2'd1);
               w.is_frac = 1'b1;
               w.phase   = PH_FRAC;
            end
         end
         if (!done) begin
            unique case (w.phase)
               PH_PREFIX, PH_INT: begin
                  if (dig_ok) begin
                     if (!w.too_big) begin
                        if (mac_over) begin
                           w.too_big = 1'b1;
                           w.accum   = '0;
                        end else begin
                           w.accum = mac[VALUE_W-1:0];
                        end
                     end
                     w.len = commit_len(w.len, 2'd1);
                  end else if (w.phase == PH_PREFIX) begin
                     fin = 1'b1;
                  end else if (c == CH_DOT) begin
                     w.phase = PH_DOT;
                  end else begin
                     try_exp = 1'b1;
                  end
               end
               PH_FRAC: begin
                  if (is_dec(c)) begin
                     w.len = commit_len(w.len, 2'd1);
                  end else begin
                     try_exp = 1'b1;
                  end
               end
               PH_EXP_E: begin
                  if (is_dec(c)) begin
                     w.len     = commit_len(w.len, 2'd2);
                     w.is_frac = 1'b1;
                     w.phase   = PH_EXP_DIG;
                  end else if (c == CH_PLUS || c == CH_MINUS) begin
                     w.phase = PH_EXP_SIGN;
                  end else begin
                     fin = 1'b1;
                  end
               end
               PH_EXP_SIGN: begin
                  if (is_dec(c)) begin
                     w.len     = commit_len(w.len, 2'd3);
                     w.is_frac = 1'b1;
                     w.phase   = PH_EXP_DIG;
                  end else begin
                     fin = 1'b1;
                  end
               end
               PH_EXP_DIG: begin
                  if (is_dec(c)) begin
                     w.len = commit_len(w.len, 2'd1);
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: w.phase = PH_IDLE;
            endcase
            if (try_exp) begin
               if (c == CH_LE || c == CH_UE) begin
                  w.phase = PH_EXP_E;
               end else begin
                  fin = 1'b1;
               end
            end
         end
         nxt = w;
         if (fin) begin
            emit      = 1'b1;
            fin_w     = w;
            nxt.phase = PH_IDLE;
         end
      end
   end

   assign result = finish(fin_w);

endmodule

// ===== src/numeric_literal_scanner.sv =====
// Top level of the numeric literal scanner: input register, step logic,
// scan state and result register. Depends on numlex_pkg, numlex_in_stage, numlex_step.
//
// The scanner takes one source character per transfer, starting at a
// literal's first digit (req_tuser bit 0), and returns one result when the
// literal ends: on the first character that does not belong to it, on a new
// begin, or on end of text (req_tuser bit 1). It recognizes 0x/0X hex, 0b/0B
// binary and decimal with optional fraction and exponent; "1..2" ends the
// integer before the dots, and a dangling 'e' or 'e+' is not counted. Integer
// values above 2^63-1 report the overflow kind with value 0; floats report
// value 0; a bare "0x"/"0b" reports the no-digit kind with length 2. Length
// counts consumed characters including the prefix and saturates at 255.
// Throughput is one character per clock with no gaps while the result register
// is free or drains; a result is registered once the character that closes the
// literal has passed the input register and the step logic. The rate is set by
// the scan state update, whose longest path is the 63-bit multiply-by-radix-and-add
// with overflow detect. While a held result waits with rsp_tready low, stepping
// stops and the input register takes at most one more character; a result that
// drains in the same cycle costs no stall.
module numeric_literal_scanner
   import numlex_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input character stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] ch
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [0] begin_req, [1] end_of_text
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [1:0] kind, [64:2] value,
                                               // [72:65] length, rest zero
);

   logic           item_valid;
   item_type       item;
   logic           advance;
   scan_state_type state_ff, state_in, step_nxt;
   logic           emit;
   result_type     step_res;
   logic           out_valid_ff, out_valid_in;
   result_type     out_res_ff, out_res_in;

   // Step a character whenever the result register is free or drains now
   assign advance = item_valid && (!out_valid_ff || rsp_tready);

   numlex_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   numlex_step u_step (
      .cur    (state_ff),
      .item   (item),
      .nxt    (step_nxt),
      .emit   (emit),
      .result (step_res)
   );

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         state_in     = step_nxt;
         out_valid_in = emit;
         if (emit) begin
            out_res_in = step_res;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_res_ff.length, out_res_ff.value, out_res_ff.kind});

endmodule

// ===== src/numlex_checker.sv =====
// Port-level checks of the numeric literal scanner, bound to the top level.
// Depends on numlex_pkg and numeric_literal_scanner.
module numlex_checker
   import numlex_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A held result stays put until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only plain integers carry a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != KIND_INT |-> rsp_tdata[VALUE_W+1:2] == '0)
      else $error("non-integer result with nonzero value");

   // A bare prefix is exactly two characters
   a_prefix_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == KIND_NO_DIGIT
         |-> rsp_tdata[VALUE_W+9:VALUE_W+2] == 8'd2)
      else $error("prefix-only result without length two");

   // Every literal consumed at least its first digit
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[VALUE_W+9:VALUE_W+2] != 8'd0)
      else $error("result with zero length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind numeric_literal_scanner numlex_checker u_numlex_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for numeric_literal_scanner: a directed table, then random literals.
// Depends on numlex_pkg and the scanner RTL only.

module testbench;
   import numlex_pkg::*;

   localparam logic [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   // One line of the directed table. Where typed is set, want holds the result
   // read straight off the spec; it replaces the prediction for that row.
   typedef struct packed {
      item_type   stim;
      logic       typed;
      result_type want;
   } row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Scan state of the predictor, kept in step with every accepted transfer
   phase_type          lex_phase    = PH_IDLE;
   logic [VALUE_W-1:0] lex_value    = '0;
   logic               lex_overflow = 1'b0;
   int                 lex_len      = 0;
   logic               lex_fraction = 1'b0;
   radix_type          lex_radix    = RADIX_DEC;

   result_type literal_results_due[$];   // predicted results, oldest first
   int         mismatches      = 0;
   int         chars_fed       = 0;      // transfers that touched a live literal
   int         literals_checked = 0;
   int         rsp_taken       = 0;
   int         kind_tally[4]   = '{default: 0};
   bit         source_idles    = 1'b1;
   bit         sink_idles      = 1'b1;

   numeric_literal_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic bit dec_char(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   // digit value in the current radix, -1 when c is not a digit of it
   function automatic int radix_digit(input logic [7:0] c);
      if (lex_radix == RADIX_BIN) return (c == CH_0 || c == CH_1) ? int'(c) - int'(CH_0) : -1;
      if (dec_char(c)) return int'(c) - int'(CH_0);
      if (lex_radix == RADIX_HEX) begin
         if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
         if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
      end
      return -1;
   endfunction

   function automatic void add_len(input int k);
      lex_len = (lex_len + k > LENGTH_LIMIT) ? LENGTH_LIMIT : lex_len + k;
   endfunction

   // value = value * radix + d; once past 2^63-1 it sticks at zero
   function automatic void take_digit(input int d);
      logic [63:0] base;
      base = (lex_radix == RADIX_HEX) ? 64'd16 : (lex_radix == RADIX_BIN) ? 64'd2 : 64'd10;
      if (lex_overflow) return;
      if ({1'b0, lex_value} > (VALUE_LIMIT - 64'(d)) / base) begin
         lex_overflow = 1'b1;
         lex_value    = '0;
      end else begin
         lex_value = VALUE_W'({1'b0, lex_value} * base + 64'(d));
      end
   endfunction

   function automatic result_type close_literal();
      result_type r;
      r.value  = '0;
      r.length = (lex_len > 255) ? 8'hFF : 8'(lex_len);
      if (lex_phase == PH_PREFIX && lex_len <= 2) begin
         r.kind = KIND_NO_DIGIT;
      end else if (lex_fraction) begin
         r.kind = KIND_FLOAT;
      end else if (lex_overflow) begin
         r.kind = KIND_OVERFLOW;
      end else begin
         r.kind  = KIND_INT;
         r.value = lex_value;
      end
      lex_phase = PH_IDLE;
      return r;
   endfunction

   // closing on end of text (or a new begin): a pending dot counts as a fraction
   function automatic result_type close_at_eot();
      if (lex_phase == PH_DOT) begin
         add_len(1);
         lex_fraction = 1'b1;
      end
      return close_literal();
   endfunction

   function automatic void open_literal(input logic [7:0] c);
      lex_value    = '0;
      lex_overflow = 1'b0;
      lex_len      = 0;
      lex_fraction = 1'b0;
      lex_radix    = RADIX_DEC;
      lex_phase    = PH_IDLE;
      if (!dec_char(c)) return;
      lex_len   = 1;
      lex_value = VALUE_W'(c - CH_0);
      lex_phase = (c == CH_0) ? PH_ZERO : PH_INT;
   endfunction

   // Advance the predictor by one transfer; returns 1 when a literal closes.
   function automatic bit scan_char(input item_type it, output result_type r);
      logic [7:0] c;
      bit         closed;
      int         d;
      c = it.ch;
      r = '0;
      // end of text wins over begin; either one closes the active literal
      if (it.end_of_text || it.begin_req) begin
         closed = (lex_phase != PH_IDLE);
         if (closed) r = close_at_eot();
         if (!it.end_of_text) open_literal(c);
         return closed;
      end
      if (lex_phase == PH_IDLE) return 0;
      if (lex_phase == PH_ZERO) begin
         if (c == CH_LX || c == CH_UX || c == CH_LB || c == CH_UB) begin
            lex_radix = (c == CH_LX || c == CH_UX) ? RADIX_HEX : RADIX_BIN;
            add_len(1);
            lex_value = '0;
            lex_phase = PH_PREFIX;
            return 0;
         end
         lex_phase = PH_INT;
      end
      // held dot: a second dot ends the integer, anything else makes a float
      if (lex_phase == PH_DOT) begin
         if (c == CH_DOT) begin
            r = close_literal();
            return 1;
         end
         add_len(1);
         lex_fraction = 1'b1;
         lex_phase    = PH_FRAC;
      end
      case (lex_phase)
         PH_PREFIX: begin
            d = radix_digit(c);
            if (d < 0) begin
               r = close_literal();
               return 1;
            end
            take_digit(d);
            add_len(1);
            return 0;
         end
         PH_INT: begin
            if (dec_char(c)) begin
               take_digit(int'(c) - int'(CH_0));
               add_len(1);
               return 0;
            end
            if (c == CH_DOT) begin
               lex_phase = PH_DOT;
               return 0;
            end
         end
         PH_FRAC: begin
            if (dec_char(c)) begin
               add_len(1);
               return 0;
            end
         end
         // the 'e' and a sign are only counted once an exponent digit shows up
         PH_EXP_E: begin
            if (dec_char(c)) begin
               add_len(2);
               lex_fraction = 1'b1;
               lex_phase    = PH_EXP_DIG;
               return 0;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
               lex_phase = PH_EXP_SIGN;
               return 0;
            end
            r = close_literal();
            return 1;
         end
         PH_EXP_SIGN: begin
            if (dec_char(c)) begin
               add_len(3);
               lex_fraction = 1'b1;
               lex_phase    = PH_EXP_DIG;
               return 0;
            end
            r = close_literal();
            return 1;
         end
         PH_EXP_DIG: begin
            if (dec_char(c)) begin
               add_len(1);
               return 0;
            end
            r = close_literal();
            return 1;
         end
         default: begin
            lex_phase = PH_IDLE;
            return 0;
         end
      endcase
      // integer or fraction hit a non-digit
      if (c == CH_LE || c == CH_UE) begin
         lex_phase = PH_EXP_E;
         return 0;
      end
      r = close_literal();
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic item_type lead(input logic [7:0] c);
      return '{ch: c, begin_req: 1'b1, end_of_text: 1'b0};
   endfunction

   function automatic item_type plain(input logic [7:0] c);
      return '{ch: c, begin_req: 1'b0, end_of_text: 1'b0};
   endfunction

   // end of text; the character byte is don't-care, so it is random
   function automatic item_type text_end();
      return '{ch: 8'($urandom_range(0, 255)), begin_req: 1'b0, end_of_text: 1'b1};
   endfunction

   function automatic logic [7:0] dec_digit();
      return CH_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] hex_digit();
      int n;
      n = $urandom_range(0, 21);
      if (n < 10) return CH_0 + 8'(n);
      if (n < 16) return CH_LA + 8'(n - 10);
      return CH_UA + 8'(n - 16);
   endfunction

   function automatic row_type quiet(input logic [7:0] c, input logic b, input logic e);
      return '{stim: '{ch: c, begin_req: b, end_of_text: e}, typed: 1'b0, want: '0};
   endfunction

   function automatic row_type yields(input logic [7:0] c, input logic b, input logic e,
                                      input kind_type k, input logic [VALUE_W-1:0] v,
                                      input logic [7:0] l);
      return '{stim: '{ch: c, begin_req: b, end_of_text: e}, typed: 1'b1,
               want: '{kind: k, value: v, length: l}};
   endfunction

   // Offer one character after a random gap, hold it until the transfer, then
   // run the predictor. Without a gap, consecutive items keep tvalid high with no dip.
   task automatic offer(input item_type it, input logic typed, input result_type want);
      int         gap;
      bit         closed;
      result_type r;
      gap = source_idles ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.ch;
      req_tuser  <= {it.end_of_text, it.begin_req};
      do @(posedge clock); while (!req_tready);
      if (it.begin_req || lex_phase != PH_IDLE) chars_fed++;
      closed = scan_char(it, r);
      if (closed) literal_results_due.push_back(typed ? want : r);
   endtask

   // whole literal: first character marked as begin, closed by end of text
   task automatic offer_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         offer(i == 0 ? lead(s[i]) : plain(s[i]), 1'b0, '0);
      end
      offer(text_end(), 1'b0, '0);
   endtask

   // Mostly well-formed literals with random content, some raw noise.
   task automatic feed_random_literal();
      item_type text[$];
      int       n;
      text = {};
      if ($urandom_range(0, 99) < 12) begin
         // raw noise: every bit of ch, begin and end of text at random
         n = $urandom_range(1, 4);
         repeat (n) text.push_back(item_type'(10'($urandom_range(0, 1023))));
      end else begin
         case ($urandom_range(0, 6))
            0: begin   // decimal integer; the long ones overflow
               text.push_back(lead(dec_digit()));
               n = $urandom_range(0, 20);
               repeat (n) text.push_back(plain(dec_digit()));
            end
            1: begin   // float with optional exponent
               text.push_back(lead(dec_digit()));
               n = $urandom_range(0, 3);
               repeat (n) text.push_back(plain(dec_digit()));
               text.push_back(plain(CH_DOT));
               n = $urandom_range(0, 4);
               repeat (n) text.push_back(plain(dec_digit()));
               if ($urandom_range(0, 1)) begin
                  text.push_back(plain($urandom_range(0, 1) ? CH_LE : CH_UE));
                  if ($urandom_range(0, 1))
                     text.push_back(plain($urandom_range(0, 1) ? CH_PLUS : CH_MINUS));
                  n = $urandom_range(1, 3);
                  repeat (n) text.push_back(plain(dec_digit()));
               end
            end
            2: begin   // exponent marker, maybe signed, closing char is random
               text.push_back(lead(dec_digit()));
               n = $urandom_range(0, 2);
               repeat (n) text.push_back(plain(dec_digit()));
               if ($urandom_range(0, 1)) begin
                  text.push_back(plain(CH_DOT));
                  text.push_back(plain(dec_digit()));
               end
               text.push_back(plain($urandom_range(0, 1) ? CH_LE : CH_UE));
               if ($urandom_range(0, 1))
                  text.push_back(plain($urandom_range(0, 1) ? CH_PLUS : CH_MINUS));
            end
            3: begin   // hex, sometimes long enough to overflow
               text.push_back(lead(CH_0));
               text.push_back(plain($urandom_range(0, 1) ? CH_LX : CH_UX));
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
               repeat (n) text.push_back(plain(hex_digit()));
            end
            4: begin   // binary, sometimes past 63 bits
               text.push_back(lead(CH_0));
               text.push_back(plain($urandom_range(0, 1) ? CH_LB : CH_UB));
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
               repeat (n) text.push_back(plain($urandom_range(0, 1) ? CH_1 : CH_0));
            end
            5: begin   // integer followed by a range operator
               text.push_back(lead(dec_digit()));
               n = $urandom_range(0, 3);
               repeat (n) text.push_back(plain(dec_digit()));
               text.push_back(plain(CH_DOT));
               text.push_back(plain(CH_DOT));
            end
            default: begin   // leading zero without a prefix
               text.push_back(lead(CH_0));
               n = $urandom_range(0, 3);
               repeat (n) text.push_back(plain(dec_digit()));
               if ($urandom_range(0, 1)) text.push_back(plain(CH_DOT));
            end
         endcase
         // how the literal is closed; with none, the next begin closes it
         case ($urandom_range(0, 3))
            0: text.push_back(plain(8'($urandom_range(0, 255))));
            1: text.push_back(text_end());
            2: ;
            default: text.push_back('{ch: 8'($urandom_range(0, 255)), begin_req: 1'b1,
                                      end_of_text: 1'b1});
         endcase
      end
      foreach (text[i]) offer(text[i], 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off so the scanner backs up
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int hold;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 24) == 0) sink_idles = ($urandom_range(0, 2) != 0);
         if (rsp_taken == 40) hold = 300;
         else hold = sink_idles ? $urandom_range(0, 10) : 0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_taken++;
      end
   end

   // Compare each result transfer with the oldest prediction.
   // tdata: [1:0] kind, [64:2] value, [72:65] length
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind   = kind_type'(rsp_tdata[1:0]);
         seen.value  = rsp_tdata[64:2];
         seen.length = rsp_tdata[72:65];
         if (literal_results_due.size() == 0) begin
            $error("result with none expected: kind %0d value %0d length %0d",
                   seen.kind, seen.value, seen.length);
            mismatches++;
         end else begin
            want = literal_results_due.pop_front();
            literals_checked++;
            kind_tally[int'(want.kind)]++;
            if (seen.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, seen.kind);
               mismatches++;
            end
            if (seen.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, seen.value);
               mismatches++;
            end
            if (seen.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, seen.length);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      row_type plan[$];
      int      guard;

      plan.push_back(quiet(8'hFF, 1'b0, 1'b1));     // end of text while idle: nothing
      plan.push_back(quiet("z", 1'b0, 1'b0));       // stray character while idle
      plan.push_back(quiet(CH_0, 1'b1, 1'b0));      // "0x" then no hex digit
      plan.push_back(quiet(CH_LX, 1'b0, 1'b0));
      plan.push_back(yields("G", 1'b0, 1'b0, KIND_NO_DIGIT, '0, 8'd2));
      plan.push_back(quiet(CH_0, 1'b1, 1'b0));      // "0B101"
      plan.push_back(quiet(CH_UB, 1'b0, 1'b0));
      plan.push_back(quiet(CH_1, 1'b0, 1'b0));
      plan.push_back(quiet(CH_0, 1'b0, 1'b0));
      plan.push_back(quiet(CH_1, 1'b0, 1'b0));
      plan.push_back(yields(CH_DOT, 1'b0, 1'b0, KIND_INT, 63'd5, 8'd5));
      plan.push_back(quiet("7", 1'b1, 1'b0));       // "7.." ends before the dots
      plan.push_back(quiet(CH_DOT, 1'b0, 1'b0));
      plan.push_back(yields(CH_DOT, 1'b0, 1'b0, KIND_INT, 63'd7, 8'd1));
      plan.push_back(quiet("4", 1'b1, 1'b0));       // "4." at end of text is a float
      plan.push_back(quiet(CH_DOT, 1'b0, 1'b0));
      plan.push_back(yields(8'h00, 1'b0, 1'b1, KIND_FLOAT, '0, 8'd2));
      plan.push_back(quiet("3", 1'b1, 1'b0));       // "3.e-;" drops the dangling exponent
      plan.push_back(quiet(CH_DOT, 1'b0, 1'b0));
      plan.push_back(quiet(CH_LE, 1'b0, 1'b0));
      plan.push_back(quiet(CH_MINUS, 1'b0, 1'b0));
      plan.push_back(yields(";", 1'b0, 1'b0, KIND_FLOAT, '0, 8'd2));
      plan.push_back(quiet("5", 1'b1, 1'b0));       // begin with end of text: only closes
      plan.push_back(yields("6", 1'b1, 1'b1, KIND_INT, 63'd5, 8'd1));
      plan.push_back(quiet("q", 1'b1, 1'b0));       // begin on a non-digit starts nothing

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) offer(plan[i].stim, plan[i].typed, plan[i].want);

      // value extremes around 2^63-1
      offer_text("0x7fffffffffffffff");
      offer_text("0X8000000000000000");
      offer_text("9223372036854775807");
      offer_text("9223372036854775808");
      offer_text("0b0");
      // length saturation: a literal longer than the length limit
      offer(lead("1"), 1'b0, '0);
      repeat (257) offer(plain(dec_digit()), 1'b0, '0);
      offer(text_end(), 1'b0, '0);

      while (chars_fed < 520) begin
         if ($urandom_range(0, 9) == 0) source_idles = ($urandom_range(0, 2) != 0);
         feed_random_literal();
      end
      offer(text_end(), 1'b0, '0);   // flush whatever literal is still open
      req_tvalid <= 1'b0;

      guard = 0;
      while (literal_results_due.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (literal_results_due.size() != 0) begin
         $error("%0d predicted results never arrived", literal_results_due.size());
         mismatches++;
      end
      repeat (10) @(posedge clock);

      $display("Scanned %0d live characters; %0d literal results checked", chars_fed,
               literals_checked);
      $display("  by kind: integer %0d, out of range %0d, float %0d, bare prefix %0d",
               kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run-time limit, far past the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/numlex_pkg.sv
src/numlex_in_stage.sv
src/numlex_step.sv
src/numeric_literal_scanner.sv
src/numlex_checker.sv
bench/testbench.sv
